// ===== design/assert_macros.svh =====
// assertion helpers used by the cipher core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every cycle out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fbc_pkg.sv =====
package fbc_pkg;

  localparam int WORD_W      = 32;
  localparam int KEY_WORDS   = 8;
  localparam int KEY_IDX_W   = 3;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int ROT_LEFT    = 11;
  localparam int SBOX_COUNT  = 8;
  localparam int SCHED_LEN   = 32;
  localparam int SCHED_IDX_W = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_bank_t;

  // one request in flight between two round cells
  typedef struct packed {
    logic  valid;
    logic  decrypt;
    word_t left;
    word_t right;
  } stage_t;

  localparam logic [3:0] SBOX [SBOX_COUNT][16] = '{
    '{4'h9, 4'h6, 4'h3, 4'h2, 4'h8, 4'hB, 4'h1, 4'h7,
      4'hA, 4'h4, 4'hE, 4'hF, 4'hC, 4'h0, 4'hD, 4'h5},
    '{4'h3, 4'h7, 4'hE, 4'h9, 4'h8, 4'hA, 4'hF, 4'h0,
      4'h5, 4'h2, 4'h6, 4'hC, 4'hB, 4'h4, 4'hD, 4'h1},
    '{4'hE, 4'h4, 4'h6, 4'h2, 4'hB, 4'h3, 4'hD, 4'h8,
      4'hC, 4'hF, 4'h5, 4'hA, 4'h0, 4'h7, 4'h1, 4'h9},
    '{4'hE, 4'h7, 4'hA, 4'hC, 4'hD, 4'h1, 4'h3, 4'h9,
      4'h0, 4'h2, 4'hB, 4'h4, 4'hF, 4'h8, 4'h5, 4'h6},
    '{4'hB, 4'h5, 4'h1, 4'h9, 4'h8, 4'hD, 4'hF, 4'h0,
      4'hE, 4'h4, 4'h2, 4'h3, 4'hC, 4'h7, 4'hA, 4'h6},
    '{4'h3, 4'hA, 4'hD, 4'hC, 4'h1, 4'h2, 4'h0, 4'hB,
      4'h7, 4'h5, 4'h9, 4'h4, 4'h8, 4'hF, 4'hE, 4'h6},
    '{4'h1, 4'hD, 4'h2, 4'h9, 4'h7, 4'hA, 4'h6, 4'h0,
      4'h8, 4'hC, 4'h4, 4'h5, 4'hF, 4'h3, 4'hB, 4'hE},
    '{4'hB, 4'hA, 4'hF, 4'h5, 4'h0, 4'hC, 4'hE, 4'h8,
      4'h6, 4'h2, 4'h3, 4'h9, 4'h1, 4'h7, 4'hD, 4'h4}
  };

  // key word used by each encryption round
  localparam logic [KEY_IDX_W-1:0] SCHED [SCHED_LEN] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
  };

  function automatic logic [KEY_IDX_W-1:0] key_sel(input int pos);
    return SCHED[pos[SCHED_IDX_W-1:0]];
  endfunction

  // key add, s-box layer, rotate left
  function automatic word_t round_mix(input word_t half, input word_t kw);
    word_t sum;
    word_t sub;
    sum = half + kw;
    for (int n = 0; n < SBOX_COUNT; n++) begin
      sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
    end
    return {sub[WORD_W-ROT_LEFT-1:0], sub[WORD_W-1:WORD_W-ROT_LEFT]};
  endfunction

endpackage

// ===== design/feistel_64bit_block_cipher_32_rounds_core.sv =====
// 64-bit feistel block cipher, 32 rounds, eight 32-bit key words
//
// key port: cfg_write with cfg_index 0..7 loads key word cfg_index from
//   cfg_data; indexes above 7 are dropped. change keys only while idle.
// request channel: req_valid, req_type (0 encrypt, 1 decrypt), block_in;
//   a request is taken on a clock edge with req_valid high, req_stall low.
// response channel: rsp_valid, block_out; taken when rsp_stall is low.
// path: an accepted request passes one register per round cell, then the
//   output register, before it shows on rsp_valid.
// throughput: one block per cycle, set by the row of round cells that all
//   move together on each cycle the skid register is empty.
// stall: when the receiver stalls a waiting response, the next finished
//   block drops into a one-deep skid register; only while that is full do
//   the cells freeze and req_stall rise. req_stall is a plain register.
// reset: rst (synchronous, active high) clears all valid flags and the
//   key words to zero.
`include "assert_macros.svh"

module feistel_64bit_block_cipher_32_rounds_core #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // key register writes
  input  logic                               cfg_write,
  input  logic [fbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic                               req_type,
  input  logic [2*fbc_pkg::WORD_W-1:0]       block_in,
  // response channel
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [2*fbc_pkg::WORD_W-1:0]       block_out
);

  localparam int LAST = ROUND_COUNT - 1;

  fbc_pkg::key_bank_t keys;
  fbc_pkg::stage_t    in_stage;
  fbc_pkg::stage_t    stage [ROUND_COUNT];

  // output register plus one-deep skid
  logic                             out_v;
  logic [2*fbc_pkg::WORD_W-1:0]     out_data;
  logic                             skid_v;
  logic [2*fbc_pkg::WORD_W-1:0]     skid_data;
  logic                             adv;
  logic                             take;

  // key words
  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_write && (cfg_index < fbc_pkg::CFG_INDEX_W'(fbc_pkg::KEY_WORDS))) begin
      keys[cfg_index[fbc_pkg::KEY_IDX_W-1:0]] <= cfg_data;
    end
  end

  // the whole row moves whenever the skid has room
  assign adv       = !skid_v;
  assign req_stall = skid_v;
  assign take      = out_v && !rsp_stall;

  // low word is the first half
  assign in_stage.valid   = req_valid;
  assign in_stage.decrypt = req_type;
  assign in_stage.left    = block_in[fbc_pkg::WORD_W-1:0];
  assign in_stage.right   = block_in[2*fbc_pkg::WORD_W-1:fbc_pkg::WORD_W];

  // row of round cells; decrypt walks the key schedule backward
  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    fbc_round_cell #(
      .ENC_KEY (fbc_pkg::key_sel(r)),
      .DEC_KEY (fbc_pkg::key_sel(LAST - r)),
      .SWAP    (r != LAST)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .keys (keys),
      .up   ((r == 0) ? in_stage : stage[(r == 0) ? 0 : r - 1]),
      .down (stage[r])
    );
  end

  // response side: last cell into output register, or skid if stalled; a full skid refills the output first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        out_v    <= 1'b1;
        out_data <= skid_data;
        skid_v   <= 1'b0;
      end
    end else if (!out_v || take) begin
      out_v    <= stage[LAST].valid;
      out_data <= {stage[LAST].right, stage[LAST].left};
    end else begin
      skid_v    <= stage[LAST].valid;
      skid_data <= {stage[LAST].right, stage[LAST].left};
    end
  end

  assign rsp_valid = out_v;
  assign block_out = out_data;

  // an accepted request lands in the first cell
  `ASSERT_NEXT(a_first_cell_loaded, req_valid && !req_stall, stage[0].valid,
               "accepted request missing from first round cell")
  // the skid only fills behind a full output register
  `ASSERT_IMPL(a_skid_behind_out, skid_v, out_v,
               "skid register full while output register empty")
  // skid fills only when the output was stalled
  `ASSERT_IMPL(a_skid_fill_cause, $rose(skid_v), $past(out_v && rsp_stall),
               "skid filled without a stalled response")
  // a finished block always shows up on the response side
  `ASSERT_NEXT(a_last_cell_drains, !skid_v && stage[LAST].valid, out_v,
               "finished block lost at the response side")

endmodule

// ===== design/fbc_round_cell.sv =====
module fbc_round_cell #(
  parameter logic [fbc_pkg::KEY_IDX_W-1:0] ENC_KEY = 3'd0,
  parameter logic [fbc_pkg::KEY_IDX_W-1:0] DEC_KEY = 3'd0,
  parameter bit                            SWAP    = 1'b1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  fbc_pkg::key_bank_t keys,
  input  fbc_pkg::stage_t    up,
  output fbc_pkg::stage_t    down
);

  fbc_pkg::word_t kw;
  fbc_pkg::word_t mixed;

  assign kw    = up.decrypt ? keys[DEC_KEY] : keys[ENC_KEY];
  assign mixed = up.left ^ fbc_pkg::round_mix(up.right, kw);

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (adv) begin
      down.valid <= up.valid;
    end
    if (adv) begin
      down.decrypt <= up.decrypt;
      // halves swap after every round but the last
      if (SWAP) begin
        down.left  <= up.right;
        down.right <= mixed;
      end else begin
        down.left  <= mixed;
        down.right <= up.right;
      end
    end
  end

endmodule
